/* rtl/core/adc_average_pt1000_temperature_core_macros.svh */
// Assertion macros used by the checker file of the temperature core.
`ifndef ADC_AVERAGE_PT1000_TEMPERATURE_CORE_MACROS_SVH
`define ADC_AVERAGE_PT1000_TEMPERATURE_CORE_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/adc_avg_pkg.sv */
// Package: widths, constants, state type and resistance table of the temperature core.
package adc_avg_pkg;

    localparam int WINDOW      = 20;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int SAMPLE_W    = 12;
    localparam int TOTAL_W     = 17;
    localparam int MEAN_W      = 12;
    localparam int REF_W       = 16;
    localparam int DIFF_W      = 13;
    localparam int PROD_W      = DIFF_W + REF_W;
    localparam int SCALED_W    = PROD_W + 4;
    localparam int ROM_ENTRIES = 310;
    localparam int ROM_W       = 15;
    localparam int IDX_W       = 9;
    localparam int BIT_W       = 4;
    localparam int TEMP_W      = 10;
    localparam int TEMP_OFFSET = 50;
    localparam int REF_RESET   = 729;
    localparam int FULL_SCALE  = 4096;
    localparam int DIV_MUL     = 52429;
    localparam int DIV_SHIFT   = 18;
    localparam int DIV_IN_W    = TOTAL_W - 2;
    localparam int DIV_PROD_W  = DIV_IN_W + 16;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;
    localparam int M_USER_W    = 2;

    typedef logic [ROM_W-1:0] rom_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MEAN,
        ST_PROD,
        ST_SCALE,
        ST_FIRST,
        ST_SEARCH,
        ST_DONE
    } state_t;

    localparam rom_word_t RTD_ROM [ROM_ENTRIES] = '{
        15'd8031, 15'd8070, 15'd8110, 15'd8150, 15'd8189,
        15'd8229, 15'd8269, 15'd8308, 15'd8348, 15'd8388,
        15'd8429, 15'd8467, 15'd8506, 15'd8546, 15'd8585,
        15'd8625, 15'd8664, 15'd8704, 15'd8743, 15'd8783,
        15'd8822, 15'd8862, 15'd8901, 15'd8940, 15'd8980,
        15'd9019, 15'd9059, 15'd9098, 15'd9137, 15'd9177,
        15'd9216, 15'd9255, 15'd9295, 15'd9334, 15'd9373,
        15'd9412, 15'd9452, 15'd9491, 15'd9530, 15'd9569,
        15'd9609, 15'd9648, 15'd9687, 15'd9726, 15'd9765,
        15'd9804, 15'd9844, 15'd9883, 15'd9922, 15'd9961,
        15'd10000, 15'd10039, 15'd10078, 15'd10117, 15'd10156,
        15'd10195, 15'd10234, 15'd10273, 15'd10312, 15'd10351,
        15'd10390, 15'd10429, 15'd10468, 15'd10507, 15'd10546,
        15'd10585, 15'd10624, 15'd10663, 15'd10702, 15'd10740,
        15'd10779, 15'd10818, 15'd10857, 15'd10896, 15'd10935,
        15'd10973, 15'd11012, 15'd11051, 15'd11090, 15'd11128,
        15'd11167, 15'd11206, 15'd11245, 15'd11283, 15'd11322,
        15'd11361, 15'd11399, 15'd11438, 15'd11477, 15'd11515,
        15'd11554, 15'd11593, 15'd11631, 15'd11670, 15'd11708,
        15'd11747, 15'd11785, 15'd11824, 15'd11862, 15'd11901,
        15'd11940, 15'd11978, 15'd12016, 15'd12055, 15'd12093,
        15'd12132, 15'd12170, 15'd12209, 15'd12247, 15'd12286,
        15'd12324, 15'd12362, 15'd12401, 15'd12439, 15'd12477,
        15'd12516, 15'd12554, 15'd12592, 15'd12631, 15'd12669,
        15'd12707, 15'd12745, 15'd12784, 15'd12822, 15'd12860,
        15'd12898, 15'd12937, 15'd12975, 15'd13013, 15'd13051,
        15'd13089, 15'd13127, 15'd13166, 15'd13204, 15'd13242,
        15'd13280, 15'd13318, 15'd13356, 15'd13394, 15'd13432,
        15'd13470, 15'd13508, 15'd13546, 15'd13584, 15'd13622,
        15'd13660, 15'd13698, 15'd13736, 15'd13774, 15'd13812,
        15'd13850, 15'd13888, 15'd13926, 15'd13964, 15'd14002,
        15'd14039, 15'd14077, 15'd14115, 15'd14153, 15'd14191,
        15'd14229, 15'd14266, 15'd14304, 15'd14342, 15'd14380,
        15'd14417, 15'd14455, 15'd14493, 15'd14531, 15'd14568,
        15'd14606, 15'd14644, 15'd14681, 15'd14719, 15'd14757,
        15'd14794, 15'd14832, 15'd14870, 15'd14907, 15'd14945,
        15'd14982, 15'd15020, 15'd15057, 15'd15095, 15'd15133,
        15'd15170, 15'd15208, 15'd15245, 15'd15283, 15'd15320,
        15'd15358, 15'd15395, 15'd15432, 15'd15470, 15'd15507,
        15'd15545, 15'd15582, 15'd15619, 15'd15657, 15'd15694,
        15'd15731, 15'd15769, 15'd15806, 15'd15843, 15'd15881,
        15'd15918, 15'd15955, 15'd15993, 15'd16030, 15'd16067,
        15'd16104, 15'd16142, 15'd16179, 15'd16216, 15'd16253,
        15'd16290, 15'd16327, 15'd16365, 15'd16402, 15'd16439,
        15'd16476, 15'd16513, 15'd16550, 15'd16587, 15'd16624,
        15'd16661, 15'd16698, 15'd16735, 15'd16772, 15'd16809,
        15'd16846, 15'd16883, 15'd16920, 15'd16957, 15'd16994,
        15'd17031, 15'd17068, 15'd17105, 15'd17142, 15'd17179,
        15'd17216, 15'd17253, 15'd17290, 15'd17326, 15'd17363,
        15'd17400, 15'd17437, 15'd17474, 15'd17510, 15'd17547,
        15'd17584, 15'd17621, 15'd17657, 15'd17694, 15'd17731,
        15'd17768, 15'd17804, 15'd17841, 15'd17878, 15'd17914,
        15'd17951, 15'd17988, 15'd18024, 15'd18061, 15'd18097,
        15'd18134, 15'd18171, 15'd18207, 15'd18244, 15'd18280,
        15'd18317, 15'd18353, 15'd18390, 15'd18426, 15'd18463,
        15'd18499, 15'd18536, 15'd18572, 15'd18609, 15'd18645,
        15'd18682, 15'd18718, 15'd18754, 15'd18791, 15'd18827,
        15'd18863, 15'd18900, 15'd18936, 15'd18972, 15'd19009,
        15'd19045, 15'd19081, 15'd19118, 15'd19154, 15'd19190,
        15'd19226, 15'd19263, 15'd19299, 15'd19335, 15'd19371,
        15'd19407, 15'd19444, 15'd19480, 15'd19516, 15'd19552,
        15'd19588, 15'd19624, 15'd19660, 15'd19696, 15'd19733
    };

    function automatic rom_word_t rtd_rom_at(input logic [IDX_W-1:0] idx);
        rom_word_t word;
        word = '1;
        if (int'(idx) < ROM_ENTRIES) begin
            word = RTD_ROM[idx];
        end
        return word;
    endfunction

endpackage

/* rtl/core/adc_average_pt1000_temperature_core.sv */
// Top level: 20-sample moving average of ADC readings and PT1000 table lookup.
// Steps from input transfer to result valid: fetch and update, mean, product, scale,
// first-entry check, 9 binary-search steps over the 310-entry table, output.
// Samples are taken only in the idle state, not while the shared search multiplier works;
// a held result stalls the next one only while the output register is still full.
// Reset (aresetn low, synchronous): ring count, slot, sum and output valid clear,
// reference resistor returns to 729 ohms; ring memory contents need no clearing.
module adc_average_pt1000_temperature_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] adc_sample, [15:12] zero
    input  logic [adc_avg_pkg::S_DATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] temp_celsius, [15:10] zero
    output logic [adc_avg_pkg::M_DATA_W-1:0] m_tdata,
    // [0] reading_ready, [1] in_range
    output logic [adc_avg_pkg::M_USER_W-1:0] m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [adc_avg_pkg::REF_W-1:0]    cfg_data
);
    import adc_avg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROM_ENTRIES - 1);

    logic [SAMPLE_W-1:0]   ring_mem [WINDOW];
    logic [SAMPLE_W-1:0]   rd_data_reg;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  full_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [REF_W-1:0]      ref_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [MEAN_W-1:0]     mean_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SCALED_W-1:0]   scaled_reg;
    logic                  low_ok_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic                  m_valid_reg;
    logic [TEMP_W-1:0]     temp_reg;
    logic                  ready_flag_reg;
    logic                  hit_reg;

    logic                  s_xfer;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   old_sample;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [DIFF_W-1:0]     diff;
    logic [IDX_W-1:0]      cand;
    logic [IDX_W-1:0]      probe_idx;
    logic [ROM_W+MEAN_W-1:0] probe_prod;
    logic                  probe_le;
    logic                  hit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign old_sample = full_reg ? rd_data_reg : '0;
    assign div_prod   = DIV_PROD_W'(total_reg[TOTAL_W-1:2]) * DIV_PROD_W'(DIV_MUL);
    assign diff       = DIFF_W'(FULL_SCALE) - DIFF_W'(mean_reg);
    assign cand       = pos_reg | (IDX_W'(1) << bit_reg);
    assign probe_idx  = (state_reg == ST_SEARCH) ? cand : '0;
    assign probe_prod = (ROM_W+MEAN_W)'(rtd_rom_at(probe_idx)) * (ROM_W+MEAN_W)'(mean_reg);
    assign probe_le   = SCALED_W'(probe_prod) <= scaled_reg;
    assign hit        = full_reg && low_ok_reg && (mean_reg != '0) && (pos_reg != LAST_IDX);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            ring_mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) state_next = ST_FETCH;
            end
            ST_FETCH:  state_next = ST_MEAN;
            ST_MEAN:   state_next = ST_PROD;
            ST_PROD:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FIRST;
            ST_FIRST:  state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (bit_reg == '0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            total_reg <= '0;
            ref_reg   <= REF_W'(REF_RESET);
        end else begin
            if (cfg_valid && cfg_ready) begin
                ref_reg <= cfg_data;
            end
            if (state_reg == ST_FETCH) begin
                total_reg <= total_reg - TOTAL_W'(old_sample) + TOTAL_W'(sample_reg);
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_reg <= '0;
                    full_reg <= 1'b1;
                end else begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (state_reg == ST_MEAN) begin
            mean_reg <= div_prod[DIV_SHIFT +: MEAN_W];
        end
        if (state_reg == ST_PROD) begin
            prod_reg <= PROD_W'(diff) * PROD_W'(ref_reg);
        end
        if (state_reg == ST_SCALE) begin
            scaled_reg <= SCALED_W'({prod_reg, 3'b000}) + SCALED_W'({prod_reg, 1'b0});
        end
        if (state_reg == ST_FIRST) begin
            low_ok_reg <= probe_le;
            pos_reg    <= '0;
            bit_reg    <= BIT_W'(IDX_W - 1);
        end
        if (state_reg == ST_SEARCH) begin
            if ((cand <= LAST_IDX) && probe_le) begin
                pos_reg <= cand;
            end
            bit_reg <= bit_reg - BIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            temp_reg       <= hit ? (TEMP_W'(pos_reg) - TEMP_W'(TEMP_OFFSET)) : '0;
            ready_flag_reg <= full_reg;
            hit_reg        <= hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(temp_reg);
    assign m_tuser  = {hit_reg, ready_flag_reg};

endmodule

/* rtl/core/adc_avg_checker.sv */
// Checker: port-level assertions on the temperature core, bound to the top level.
`include "adc_average_pt1000_temperature_core_macros.svh"

module adc_avg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [adc_avg_pkg::M_DATA_W-1:0] m_tdata,
    input logic [adc_avg_pkg::M_USER_W-1:0] m_tuser
);
    import adc_avg_pkg::*;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_tvalid)
    `ASSERT_IMPLY(a_not_ready_zero, aclk, aresetn, m_tvalid && !m_tuser[0], (m_tdata == '0) && !m_tuser[1])
    `ASSERT_IMPLY(a_range_bounds, aclk, aresetn, m_tvalid && m_tuser[1], ($signed(m_tdata[TEMP_W-1:0]) >= -10'sd50) && ($signed(m_tdata[TEMP_W-1:0]) <= 10'sd258))

endmodule

bind adc_average_pt1000_temperature_core adc_avg_checker u_adc_avg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
